// ===== hdl/tso_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tso_pkg: shared types and constants for texture_slice_offset
// Payload words, configuration register indexes, multiply operation codes and
// the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package tso_pkg;

  // largest number of stored mip levels that the level loop will walk
  localparam int MAX_MIP_LEVELS = 16;

  // width of the offset field in a result word
  localparam int OUT_OFFSET_W = 48;

  // block sizes of the two compressed classes
  localparam logic [4:0] BLK8_BYTES  = 5'd8;
  localparam logic [4:0] BLK16_BYTES = 5'd16;

  // format class codes
  localparam logic [2:0] FMT_BPP1  = 3'd0;
  localparam logic [2:0] FMT_BPP2  = 3'd1;
  localparam logic [2:0] FMT_BPP3  = 3'd2;
  localparam logic [2:0] FMT_BPP4  = 3'd3;
  localparam logic [2:0] FMT_BPP8  = 3'd4;
  // first block-compressed format class
  localparam logic [2:0] FMT_BLK8  = 3'd5;
  localparam logic [2:0] FMT_BLK16 = 3'd6;

  // input word
  typedef struct packed {
    logic [3:0]  mip_level;
    logic [15:0] frame_index;
    logic [2:0]  face_index;
    logic [15:0] depth_slice;
  } tso_in_t;

  // result word
  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] byte_offset;
    logic                    overflow;
  } tso_out_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FORMAT_CLASS = 3'd0;
  localparam logic [2:0] CFG_BASE_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_BASE_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_BASE_DEPTH   = 3'd3;
  localparam logic [2:0] CFG_FACE_COUNT   = 3'd4;
  localparam logic [2:0] CFG_FRAME_COUNT  = 3'd5;
  localparam logic [2:0] CFG_MIP_COUNT    = 3'd6;

  // configuration reset values
  localparam logic [2:0]  RST_FORMAT_CLASS = 3'd3;
  localparam logic [15:0] RST_BASE_EXTENT  = 16'd1;
  localparam logic [2:0]  RST_FACE_COUNT   = 3'd1;
  localparam logic [15:0] RST_FRAME_COUNT  = 16'd1;
  localparam logic [4:0]  RST_MIP_COUNT    = 5'd1;

  // multiply operations, each with its operands and destination
  typedef logic [2:0] tso_op_t;
  localparam tso_op_t MOP_WH        = 3'd0;  // width x height -> slice
  localparam tso_op_t MOP_BPP       = 3'd1;  // slice x bytes per unit -> slice
  localparam tso_op_t MOP_DEPTH     = 3'd2;  // slice x depth -> face
  localparam tso_op_t MOP_FACES     = 3'd3;  // face x face count -> frame
  localparam tso_op_t MOP_FRAMES    = 3'd4;  // frame x frame count -> acc
  localparam tso_op_t MOP_FRAME_IDX = 3'd5;  // frame x frame index -> acc
  localparam tso_op_t MOP_FACE_IDX  = 3'd6;  // face x face index -> acc
  localparam tso_op_t MOP_DEPTH_IDX = 3'd7;  // slice x depth slice -> acc

  // controller to datapath
  typedef struct packed {
    logic    load;        // capture input word, clear acc, start above wanted level
    logic    go;          // launch a multiply
    tso_op_t op;          // which multiply
    logic    set_wanted;  // move level counter to the wanted level
    logic    lvl_inc;     // step to the next smaller level
    logic    out_fire;    // present the result word
  } tso_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;   // multiply result written this cycle
    logic lvl_more;   // level counter below stored level count
  } tso_sts_t;

  // bytes per pixel, or per block for the compressed classes
  function automatic logic [4:0] fmt_scale(input logic [2:0] fmt);
    logic [4:0] s;
    case (fmt)
      FMT_BPP1: s = 5'd1;
      FMT_BPP2: s = 5'd2;
      FMT_BPP3: s = 5'd3;
      FMT_BPP4: s = 5'd4;
      FMT_BPP8: s = 5'd8;
      FMT_BLK8: s = BLK8_BYTES;
      default:  s = BLK16_BYTES;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/texture_slice_offset.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// texture_slice_offset: byte offset of one 2-D slice in a mip-chained texture
// Sums the sizes of all smaller stored levels, then frame, face and slice
// strides of the wanted level, saturating at 2^OFFSET_BITS-1.
//
//   channel   ports                              handshake
//   input     start, busy, in_data               taken when start && !busy
//   result    out_valid, out_data                one-cycle strobe, no stall
//   config    cfg_we, cfg_idx, cfg_wdata         written when cfg_we
//
// One word at a time. Every size is built by one shared 32x16 multiplier
// that takes one 32-bit piece of its wide operand per cycle; an operand has
// ceil(OFFSET_BITS/32) pieces. Each smaller level walked takes five
// multiplies and the wanted level seven.
// Reset brings configuration to its defaults and the sequencer to idle;
// the result strobe is never held off.
// ----------------------------------------------------------------------------
module texture_slice_offset
  import tso_pkg::*;
#(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire tso_in_t     in_data,
  output logic             out_valid,
  output tso_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  tso_cmd_t cmd;
  tso_sts_t sts;

  tso_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tso_dpath #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/tso_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tso_mul: saturating multi-cycle multiplier
// Multiplies a saturating offset value by a 16-bit factor, one 32-bit piece of
// the wide operand per cycle, and clamps the product at the offset cap.
// ----------------------------------------------------------------------------
module tso_mul
  import tso_pkg::*;
#(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire logic [OFFSET_BITS-1:0] a_v,
  input  wire logic                   a_ovf,
  input  wire logic [15:0]            b,
  output logic                        done,
  output logic [OFFSET_BITS-1:0]      res_v,
  output logic                        res_ovf
);

  localparam int NPC = (OFFSET_BITS + 31) / 32;
  localparam int AW  = NPC * 32;
  localparam int PW  = AW + 16;
  localparam int CW  = $clog2(NPC + 1);

  logic [AW-1:0] a_sh_r;
  logic [15:0]   b_r;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] cnt_r;
  logic          zero_r, aovf_r;
  logic          run_r, done_r;
  logic [47:0]   pp;
  logic          hi_set;

  // one partial product per cycle, most significant piece first
  assign pp       = a_sh_r[AW-1 -: 32] * b_r;
  assign prod_nxt = (prod_r << 32) + PW'(pp);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (go) begin
      a_sh_r <= AW'(a_v);
      b_r    <= b;
      prod_r <= '0;
      cnt_r  <= CW'(NPC);
      zero_r <= (a_v == '0) || (b == '0);
      aovf_r <= a_ovf;
    end else if (run_r) begin
      a_sh_r <= a_sh_r << 32;
      prod_r <= prod_nxt;
      cnt_r  <= cnt_r - CW'(1);
    end
  end

  // clamp at the cap; a zero operand clears any earlier overflow
  assign hi_set  = |prod_r[PW-1:OFFSET_BITS];
  assign res_ovf = !zero_r && (aovf_r || hi_set);
  assign res_v   = zero_r  ? '0 :
                   res_ovf ? {OFFSET_BITS{1'b1}} : prod_r[OFFSET_BITS-1:0];
  assign done    = done_r;

endmodule
`default_nettype wire

// ===== hdl/tso_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tso_dpath: offset datapath
// Holds configuration, the current word, level extents, slice/face/frame
// sizes and the saturating offset accumulator around one shared multiplier.
// ----------------------------------------------------------------------------
module tso_dpath
  import tso_pkg::*;
#(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tso_in_t  in_data,
  input  wire logic     cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  input  wire tso_cmd_t cmd,
  output tso_sts_t      sts,
  output logic          out_valid,
  output tso_out_t      out_data
);

  localparam int EW = (OFFSET_BITS > OUT_OFFSET_W) ? OFFSET_BITS : OUT_OFFSET_W;

  // configuration registers
  logic [2:0]  fmt_r;
  logic [15:0] base_w_r, base_h_r, base_d_r;
  logic [2:0]  face_cnt_r;
  logic [15:0] frame_cnt_r;
  logic [4:0]  mip_cnt_r;

  // current word
  logic [3:0]  want_lvl_r;
  logic [15:0] frame_idx_r;
  logic [2:0]  face_idx_r;
  logic [15:0] depth_idx_r;

  logic [4:0]  lvl_r;
  tso_op_t     op_r;

  logic [OFFSET_BITS-1:0] slice_v_r, face_v_r, frame_v_r, acc_v_r;
  logic                   slice_o_r, face_o_r, frame_o_r, acc_o_r;

  logic                   out_valid_r;
  tso_out_t               out_data_r;

  logic [15:0] ext_w, ext_h, ext_d, sh_w, sh_h, sh_d;
  logic [16:0] bw_sum, bh_sum;
  logic [15:0] blk_w, blk_h, opnd_w, opnd_h;
  logic [4:0]  levels;

  logic [OFFSET_BITS-1:0] mul_a;
  logic                   mul_aovf;
  logic [15:0]            mul_b;
  logic                   mul_done;
  logic [OFFSET_BITS-1:0] mul_v;
  logic                   mul_ovf;

  logic [OFFSET_BITS:0]   sum;
  logic                   add_ovf;
  logic [EW-1:0]          acc_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= RST_FORMAT_CLASS;
      base_w_r    <= RST_BASE_EXTENT;
      base_h_r    <= RST_BASE_EXTENT;
      base_d_r    <= RST_BASE_EXTENT;
      face_cnt_r  <= RST_FACE_COUNT;
      frame_cnt_r <= RST_FRAME_COUNT;
      mip_cnt_r   <= RST_MIP_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FORMAT_CLASS: fmt_r       <= cfg_wdata[2:0];
        CFG_BASE_WIDTH:   base_w_r    <= cfg_wdata;
        CFG_BASE_HEIGHT:  base_h_r    <= cfg_wdata;
        CFG_BASE_DEPTH:   base_d_r    <= cfg_wdata;
        CFG_FACE_COUNT:   face_cnt_r  <= cfg_wdata[2:0];
        CFG_FRAME_COUNT:  frame_cnt_r <= cfg_wdata;
        CFG_MIP_COUNT:    mip_cnt_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // extents of the current level, each at least one
  assign sh_w  = base_w_r >> lvl_r;
  assign sh_h  = base_h_r >> lvl_r;
  assign sh_d  = base_d_r >> lvl_r;
  assign ext_w = (sh_w == '0) ? 16'd1 : sh_w;
  assign ext_h = (sh_h == '0) ? 16'd1 : sh_h;
  assign ext_d = (sh_d == '0) ? 16'd1 : sh_d;

  // block counts, at least one 4x4 block each way
  assign bw_sum = {1'b0, ext_w} + 17'd3;
  assign bh_sum = {1'b0, ext_h} + 17'd3;
  assign blk_w  = (ext_w < 16'd4) ? 16'd1 : {1'b0, bw_sum[16:2]};
  assign blk_h  = (ext_h < 16'd4) ? 16'd1 : {1'b0, bh_sum[16:2]};
  assign opnd_w = (fmt_r >= FMT_BLK8) ? blk_w : ext_w;
  assign opnd_h = (fmt_r >= FMT_BLK8) ? blk_h : ext_h;

  // stored levels, clamped
  assign levels = (mip_cnt_r > 5'(MAX_MIP_LEVELS)) ? 5'(MAX_MIP_LEVELS) : mip_cnt_r;

  // multiplier operand select
  always_comb begin
    mul_a    = slice_v_r;
    mul_aovf = slice_o_r;
    mul_b    = depth_idx_r;
    case (cmd.op)
      MOP_WH: begin
        mul_a    = OFFSET_BITS'(opnd_w);
        mul_aovf = 1'b0;
        mul_b    = opnd_h;
      end
      MOP_BPP:   mul_b = 16'(fmt_scale(fmt_r));
      MOP_DEPTH: mul_b = ext_d;
      MOP_FACES: begin
        mul_a    = face_v_r;
        mul_aovf = face_o_r;
        mul_b    = 16'(face_cnt_r);
      end
      MOP_FRAMES: begin
        mul_a    = frame_v_r;
        mul_aovf = frame_o_r;
        mul_b    = frame_cnt_r;
      end
      MOP_FRAME_IDX: begin
        mul_a    = frame_v_r;
        mul_aovf = frame_o_r;
        mul_b    = frame_idx_r;
      end
      MOP_FACE_IDX: begin
        mul_a    = face_v_r;
        mul_aovf = face_o_r;
        mul_b    = 16'(face_idx_r);
      end
      default: mul_b = depth_idx_r;
    endcase
  end

  tso_mul #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (cmd.go),
    .a_v     (mul_a),
    .a_ovf   (mul_aovf),
    .b       (mul_b),
    .done    (mul_done),
    .res_v   (mul_v),
    .res_ovf (mul_ovf)
  );

  // saturating add into the accumulator
  assign sum     = {1'b0, acc_v_r} + {1'b0, mul_v};
  assign add_ovf = acc_o_r || mul_ovf || sum[OFFSET_BITS];

  // level counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (cmd.load) begin
      lvl_r <= {1'b0, in_data.mip_level} + 5'd1;
    end else if (cmd.set_wanted) begin
      lvl_r <= {1'b0, want_lvl_r};
    end else if (cmd.lvl_inc) begin
      lvl_r <= lvl_r + 5'd1;
    end
  end

  // word capture, operation latch and size registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      want_lvl_r  <= in_data.mip_level;
      frame_idx_r <= in_data.frame_index;
      face_idx_r  <= in_data.face_index;
      depth_idx_r <= in_data.depth_slice;
      acc_v_r     <= '0;
      acc_o_r     <= 1'b0;
    end
    if (cmd.go) begin
      op_r <= cmd.op;
    end
    if (mul_done) begin
      case (op_r)
        MOP_WH, MOP_BPP: begin
          slice_v_r <= mul_v;
          slice_o_r <= mul_ovf;
        end
        MOP_DEPTH: begin
          face_v_r <= mul_v;
          face_o_r <= mul_ovf;
        end
        MOP_FACES: begin
          frame_v_r <= mul_v;
          frame_o_r <= mul_ovf;
        end
        default: begin
          acc_v_r <= add_ovf ? {OFFSET_BITS{1'b1}} : sum[OFFSET_BITS-1:0];
          acc_o_r <= add_ovf;
        end
      endcase
    end
  end

  // result word
  assign acc_ext = EW'(acc_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_data_r.byte_offset <= acc_ext[OUT_OFFSET_W-1:0];
      out_data_r.overflow    <= acc_o_r;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.lvl_more = lvl_r < levels;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/tso_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tso_ctrl: offset sequencer
// Walks the smaller levels and then the wanted level, issuing one multiply
// at a time to the datapath and firing the result word at the end.
// ----------------------------------------------------------------------------
module tso_ctrl
  import tso_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire tso_sts_t sts,
  output tso_cmd_t      cmd,
  output logic          busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  tso_op_t    op_r, op_nxt;
  logic       wanted_r, wanted_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    wanted_nxt = wanted_r;
    cmd        = '0;
    cmd.op     = op_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          wanted_nxt = 1'b0;
          state_nxt  = ST_CHECK;
        end
      end
      // either another smaller level or on to the wanted one
      ST_CHECK: begin
        op_nxt    = MOP_WH;
        state_nxt = ST_ISSUE;
        if (!sts.lvl_more) begin
          cmd.set_wanted = 1'b1;
          wanted_nxt     = 1'b1;
        end
      end
      ST_ISSUE: begin
        cmd.go    = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = ST_ISSUE;
          case (op_r)
            MOP_WH:        op_nxt = MOP_BPP;
            MOP_BPP:       op_nxt = MOP_DEPTH;
            MOP_DEPTH:     op_nxt = MOP_FACES;
            MOP_FACES:     op_nxt = wanted_r ? MOP_FRAME_IDX : MOP_FRAMES;
            MOP_FRAMES: begin
              cmd.lvl_inc = 1'b1;
              state_nxt   = ST_CHECK;
            end
            MOP_FRAME_IDX: op_nxt = MOP_FACE_IDX;
            MOP_FACE_IDX:  op_nxt = MOP_DEPTH_IDX;
            default:       state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= MOP_WH;
      wanted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      wanted_r <= wanted_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ===== hdl/tso_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tso_chk: port-level checks for texture_slice_offset
// Watches the start/busy handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module tso_chk
  import tso_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // an accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // busy only rises after a start
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // one word gives one strobe cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the result appears as the block goes idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a word");

endmodule

bind texture_slice_offset tso_chk u_tso_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire
